@@ hw/rtl/plt_pkg.sv @@
package plt_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int ST_W   = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRIOR  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_NOPRIOR  = 3'd4;
    localparam logic [ST_W-1:0] ST_NONEXT   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         list_length;
        logic                     is_empty;
    } t_out_beat;

endpackage

@@ hw/rtl/plt_ram.sv @@
module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/plt_ctrl.sv @@
module plt_ctrl #(
    parameter int CAPACITY = plt_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  plt_pkg::t_in_beat         i_in,
    output logic                      o_res_valid,
    input  logic                      i_res_take,
    output plt_pkg::t_out_beat        o_res,
    output logic                      o_ram_we,
    output logic [AW-1:0]             o_ram_waddr,
    output logic [plt_pkg::DATA_W-1:0] o_ram_wdata,
    output logic [AW-1:0]             o_ram_raddr,
    input  logic [plt_pkg::DATA_W-1:0] i_ram_rdata
);

    import plt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SETR = 3'd3;
    localparam logic [2:0] S_SETW = 3'd4;
    localparam logic [2:0] S_INSW = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [CW-1:0]     r_base, n_base;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_more, n_more;
    logic              r_down, n_down;
    logic              r_dv, n_dv;
    logic [CW-1:0]     r_didx, n_didx;
    logic [DATA_W-1:0] r_prev, n_prev;
    logic              r_nwait, n_nwait;
    logic [ST_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic [POS_W-1:0]  r_fpos, n_fpos;

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     didx_p1;
    logic [CW-1:0]     didx_up;
    logic [CW-1:0]     didx_dn;
    logic [CW-1:0]     lim;
    logic              issue;
    logic              hit;

    assign pos_x   = XW'(i_in.position);
    assign cnt_x   = XW'(r_count);
    assign didx_p1 = XW'(r_didx) + 1'b1;
    assign didx_up = r_didx + 1'b1;
    assign didx_dn = r_didx - 1'b1;
    // insert walks down to the insert slot, delete and search walk up to the tail
    assign lim     = r_down ? r_base : r_count - 1'b1;
    assign issue   = (r_state == S_MOVE || r_state == S_SCAN) && r_more;
    assign hit     = (i_ram_rdata == r_val);

    // Reads run one entry ahead of the writes: an insert writes k+1 while reading
    // k-1, a delete writes k-1 while reading k+1, so read and write never collide.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_base      = r_base;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_more      = r_more;
        n_down      = r_down;
        n_dv        = issue;
        n_didx      = r_ptr;
        n_prev      = r_prev;
        n_nwait     = r_nwait;
        n_status    = r_status;
        n_data      = r_data;
        n_fpos      = r_fpos;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_base[AW-1:0];
        o_ram_wdata = r_val;

        if (issue) begin
            if (r_ptr == lim) begin
                n_more = 1'b0;
            end else if (r_down) begin
                n_ptr = r_ptr - 1'b1;
            end else begin
                n_ptr = r_ptr + 1'b1;
            end
        end
        if (r_dv) begin
            n_prev = i_ram_rdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in.command;
                    n_val    = i_in.value;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_fpos   = '0;
                    n_nwait  = 1'b0;
                    n_base   = CW'(pos_x - 1'b1);
                    n_state  = S_RES;
                    case (i_in.command)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_INSERT: begin
                            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                                n_status = ST_BADPOS;
                            end else if (cnt_x == XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_x == cnt_x + 1'b1) begin
                                n_state = S_INSW;
                            end else begin
                                n_state = S_MOVE;
                                n_down  = 1'b1;
                                n_more  = 1'b1;
                                n_ptr   = r_count - 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_state = S_MOVE;
                                n_down  = 1'b0;
                                n_more  = 1'b1;
                                n_ptr   = CW'(pos_x - 1'b1);
                            end
                        end
                        CMD_SET: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_state = S_SETR;
                                n_ptr   = CW'(pos_x - 1'b1);
                            end
                        end
                        CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                                n_down  = 1'b0;
                                n_more  = 1'b1;
                                n_ptr   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (r_dv) begin
                    if (r_down) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = didx_up[AW-1:0];
                        o_ram_wdata = i_ram_rdata;
                    end else if (r_didx == r_base) begin
                        n_data = i_ram_rdata;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = didx_dn[AW-1:0];
                        o_ram_wdata = i_ram_rdata;
                    end
                    if (r_didx == lim) begin
                        if (r_down) begin
                            n_state = S_INSW;
                        end else begin
                            n_count = r_count - 1'b1;
                            n_state = S_RES;
                        end
                    end
                end
            end
            S_INSW: begin
                o_ram_we = 1'b1;
                n_count  = r_count + 1'b1;
                n_state  = S_RES;
            end
            S_SETR: begin
                n_state = S_SETW;
            end
            S_SETW: begin
                n_data   = i_ram_rdata;
                o_ram_we = 1'b1;
                n_state  = S_RES;
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (r_nwait) begin
                        // beat after the match carries the following entry
                        n_data  = i_ram_rdata;
                        n_state = S_RES;
                    end else if (hit) begin
                        case (r_cmd)
                            CMD_LOCATE: begin
                                n_fpos  = didx_p1[POS_W-1:0];
                                n_state = S_RES;
                            end
                            CMD_PRIOR: begin
                                if (r_didx == '0) begin
                                    n_status = ST_NOPRIOR;
                                end else begin
                                    n_data = r_prev;
                                end
                                n_state = S_RES;
                            end
                            default: begin
                                if (r_didx == lim) begin
                                    n_status = ST_NONEXT;
                                    n_state  = S_RES;
                                end else begin
                                    n_nwait = 1'b1;
                                end
                            end
                        endcase
                    end else if (r_didx == lim) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_RES;
                    end
                end
            end
            S_RES: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_more  <= 1'b0;
            r_dv    <= 1'b0;
            r_nwait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_more  <= n_more;
            r_dv    <= n_dv;
            r_nwait <= n_nwait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_base   <= n_base;
        r_val    <= n_val;
        r_ptr    <= n_ptr;
        r_down   <= n_down;
        r_didx   <= n_didx;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_data   <= n_data;
        r_fpos   <= n_fpos;
    end

    logic [XW-1:0] len_x;
    assign len_x = XW'(r_count);

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_res_valid          = (r_state == S_RES);
    assign o_res.status         = r_status;
    assign o_res.data_out       = r_data;
    assign o_res.found_position = r_fpos;
    assign o_res.list_length    = len_x[POS_W-1:0];
    assign o_res.is_empty       = (r_count == '0);
    assign o_ram_raddr          = r_ptr[AW-1:0];

endmodule

@@ hw/rtl/positional_list_table.sv @@
// Ordered list of signed 32-bit values held in one single-port-read RAM of
// CAPACITY entries, with insert/delete/set at a 1-based position, first-match
// locate and prior/next neighbor lookup; one result beat per command beat.
// Commands run one at a time and the input stalls until the current one has
// moved its result into the output register, which lets the next command
// start while that result waits. Clear, unused codes and the bad-position and
// full cases need no RAM walk; set reads and then writes one entry; append
// writes one entry; insert at position p inside the list, delete and
// locate/prior/next walk the RAM one entry per cycle.
// No clearing pass after reset: entries are read only after being written.
module positional_list_table #(
    parameter int CAPACITY = plt_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  plt_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output plt_pkg::t_out_beat o_out
);

    import plt_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              res_valid;
    logic              res_take;
    t_out_beat         res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              r_out_vld;
    t_out_beat         r_out;

    plt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    plt_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_take = res_valid && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a command was still running");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.list_length == POS_W'(CAPACITY))
        else $error("full status with a list that is not at capacity");

    a_fpos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.found_position != '0 |-> o_out.status == ST_OK)
        else $error("found position reported on a failed command");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_NOTFOUND
            |-> o_out.data_out == '0 && o_out.found_position == '0)
        else $error("miss carries data");

endmodule

@@ tb/list_table_checker.sv @@
`timescale 1ns / 100ps
module list_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  plt_pkg::t_in_beat  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  plt_pkg::t_out_beat i_out,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_model_len
);
    import plt_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    logic signed [DATA_W-1:0] list_vals [CAP];
    int                       list_len;
    t_out_beat                pending_replies [$];
    int                       mismatches;

    // Applies one command to the shadow list and returns the reply it must produce.
    function automatic t_out_beat apply_command(input t_in_beat c);
        t_out_beat r;
        int        p;
        int        k;
        int        idx;
        r = '0;
        p = int'(c.position);
        case (c.command)
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = list_len; k >= p; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[p-1] = c.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data_out = list_vals[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            CMD_SET: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data_out = list_vals[p-1];
                    list_vals[p-1] = c.value;
                end
            end
            CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                idx = list_len;
                for (k = list_len - 1; k >= 0; k--)
                    if (list_vals[k] == c.value)
                        idx = k;
                if (idx >= list_len) begin
                    r.status = ST_NOTFOUND;
                end else if (c.command == CMD_LOCATE) begin
                    r.found_position = POS_W'(idx + 1);
                end else if (c.command == CMD_PRIOR) begin
                    if (idx == 0)
                        r.status = ST_NOPRIOR;
                    else
                        r.data_out = list_vals[idx-1];
                end else begin
                    if (idx + 1 >= list_len)
                        r.status = ST_NONEXT;
                    else
                        r.data_out = list_vals[idx+1];
                end
            end
            default: begin
            end
        endcase
        r.list_length = POS_W'(list_len);
        r.is_empty    = (list_len == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            list_len = 0;
            mismatches = 0;
            pending_replies.delete();
        end else begin
            // a reply beat can never belong to the command accepted at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no command waiting: st=%0d data=%0d",
                                 $realtime, i_out.status, i_out.data_out);
                end else begin
                    want = pending_replies.pop_front();
                    if (want.status !== i_out.status || want.data_out !== i_out.data_out
                        || want.found_position !== i_out.found_position
                        || want.list_length !== i_out.list_length
                        || want.is_empty !== i_out.is_empty) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp st=%0d data=%0d fpos=%0d len=%0d ",
                                      "empty=%0b got st=%0d data=%0d fpos=%0d len=%0d empty=%0b"},
                                     $realtime, want.status, want.data_out,
                                     want.found_position, want.list_length, want.is_empty,
                                     i_out.status, i_out.data_out, i_out.found_position,
                                     i_out.list_length, i_out.is_empty);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_replies.push_back(apply_command(i_in));
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_replies.size();
        o_model_len  <= list_len;
    end

endmodule

@@ tb/tb_positional_list_table.sv @@
`timescale 1ns / 100ps
module tb_positional_list_table;
    import plt_pkg::*;

    localparam int               CAP        = CAPACITY_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] TAG_VALUE = 32'sh5A5A_0001;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      idling    = 1'b0;

    int fail_count;
    int pending;
    int model_len;

    logic signed [DATA_W-1:0] recent_values [$];

    positional_list_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    list_table_checker u_list_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_model_len  (model_len)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= idling && ($urandom_range(99) < 32);
    end

    // Drives one command beat and returns at the edge where it is taken.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
        t_in_beat b;
        b.command  = cmd;
        b.position = pos;
        b.value    = val;
        while (idling && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_INSERT || cmd == CMD_SET) begin
            recent_values.push_back(val);
            if (recent_values.size() > 32)
                void'(recent_values.pop_front());
        end
    endtask

    // model_len may lag by one command; an off-by-one position is just extra noise.
    task automatic send_random_command();
        int                       len;
        int                       roll;
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        len  = model_len;
        roll = $urandom_range(99);
        pos  = POS_W'($urandom_range(511));
        // narrow values give duplicates, so first-match rules get exercised
        val  = ($urandom_range(99) < 40) ? $signed($urandom_range(15)) - 8 : $signed($urandom());
        if (roll < 2) begin
            cmd = CMD_CLEAR;
        end else if (roll < 4) begin
            cmd = CMD_UNUSED;
        end else if (roll < (len < 24 ? 44 : 24)) begin
            cmd = CMD_INSERT;
            if ($urandom_range(99) < 85)
                pos = POS_W'($urandom_range(len + 1, 1));
        end else begin
            case ($urandom_range(4))
                0:       cmd = CMD_DELETE;
                1:       cmd = CMD_SET;
                2:       cmd = CMD_LOCATE;
                3:       cmd = CMD_PRIOR;
                default: cmd = CMD_NEXT;
            endcase
            if (cmd == CMD_DELETE || cmd == CMD_SET) begin
                if (len > 0 && $urandom_range(99) < 85)
                    pos = POS_W'($urandom_range(len, 1));
            end else if (recent_values.size() > 0 && $urandom_range(99) < 70) begin
                val = recent_values[$urandom_range(recent_values.size() - 1)];
            end
        end
        send_cmd(cmd, pos, val);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n  <= 1'b1;
        idling <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, then a short list with extreme values
        send_cmd(CMD_LOCATE, 9'd0, 32'sd5);
        send_cmd(CMD_PRIOR, 9'd0, 32'sd5);
        send_cmd(CMD_NEXT, 9'd0, 32'sd5);
        send_cmd(CMD_DELETE, 9'd1, 32'sd0);
        send_cmd(CMD_SET, 9'd0, 32'sd1);
        send_cmd(CMD_INSERT, 9'd0, 32'sd1);
        send_cmd(CMD_INSERT, 9'd2, 32'sd1);
        send_cmd(CMD_INSERT, 9'd1, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 9'd2, 32'sh7FFF_FFFF);
        send_cmd(CMD_INSERT, 9'd1, 32'sd0);
        send_cmd(CMD_INSERT, 9'd4, -32'sd1);
        send_cmd(CMD_INSERT, 9'd511, 32'sd3);
        send_cmd(CMD_LOCATE, 9'd0, 32'sh8000_0000);
        send_cmd(CMD_PRIOR, 9'd0, 32'sd0);
        send_cmd(CMD_NEXT, 9'd0, -32'sd1);
        send_cmd(CMD_PRIOR, 9'd0, 32'sh7FFF_FFFF);
        send_cmd(CMD_NEXT, 9'd0, 32'sh8000_0000);
        send_cmd(CMD_SET, 9'd4, 32'sh5555_5555);
        send_cmd(CMD_SET, 9'd5, 32'sd7);
        send_cmd(CMD_DELETE, 9'd1, 32'sd0);
        send_cmd(CMD_DELETE, 9'd3, 32'sd0);
        send_cmd(CMD_DELETE, 9'd256, 32'sd0);
        send_cmd(CMD_UNUSED, 9'h1FF, -32'sd1);
        send_cmd(CMD_CLEAR, 9'd0, 32'sd0);
        send_cmd(CMD_LOCATE, 9'd0, 32'sh8000_0000);

        repeat (150)
            send_random_command();

        // fill to capacity with no idling on either side
        idling <= 1'b0;
        send_cmd(CMD_CLEAR, 9'd0, 32'sd0);
        while (model_len < CAP)
            send_cmd(CMD_INSERT, POS_W'($urandom_range(model_len + 1, 1)), $signed($urandom()));
        send_cmd(CMD_INSERT, 9'd257, 32'sd11);
        send_cmd(CMD_INSERT, 9'd258, 32'sd12);
        send_cmd(CMD_INSERT, 9'd1, 32'sd13);
        send_cmd(CMD_SET, 9'd256, TAG_VALUE);
        send_cmd(CMD_LOCATE, 9'd0, TAG_VALUE);
        send_cmd(CMD_NEXT, 9'd0, TAG_VALUE);
        send_cmd(CMD_PRIOR, 9'd0, TAG_VALUE);
        send_cmd(CMD_DELETE, 9'd256, 32'sd0);
        send_cmd(CMD_INSERT, 9'd256, TAG_VALUE);
        send_cmd(CMD_LOCATE, 9'd0, TAG_VALUE);
        repeat (20)
            send_random_command();
        idling <= 1'b1;
        send_cmd(CMD_CLEAR, 9'd0, 32'sd0);

        repeat (100)
            send_random_command();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/plt_pkg.sv
hw/rtl/plt_ram.sv
hw/rtl/plt_ctrl.sv
hw/rtl/positional_list_table.sv
tb/list_table_checker.sv
tb/tb_positional_list_table.sv
